[rtl/ccp_pkg.sv]
// Shared types and constants for the circumcircle pipeline.
package ccp_pkg;

    localparam int OUT_W  = 32;
    localparam int RAD_W  = 31;
    localparam int LIM_W  = 33;
    localparam int AD_W   = 31;
    localparam int SQ_W   = 63;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 33;

    localparam logic [LIM_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
    localparam logic [LIM_W-1:0] NEG_LIMIT = 33'h0_8000_0000;

    typedef struct packed {
        logic coll;
        logic neg_x;
        logic neg_y;
    } t_dflag;

    typedef struct packed {
        logic coll;
        logic clip;
        logic big;
    } t_sflag;

endpackage

[rtl/circumcircle_from_three_points.sv]
// circumcircle_from_three_points: center and radius of the circle through three points.
// Stages in order: ccp_numer, ccp_div, ccp_dist, ccp_sqrt, then the output register.
// Throughput: one result per cycle unless stalled; bit-per-stage quotient and root pipelines.
// A held output stall freezes every stage together; no transaction is lost or repeated.
// Reset (synchronous, i_rst_n low) clears all valid bits; data registers are not reset.
module circumcircle_from_three_points #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_first_x,
    input  logic [COORD_BITS-1:0] i_first_y,
    input  logic [COORD_BITS-1:0] i_second_x,
    input  logic [COORD_BITS-1:0] i_second_y,
    input  logic [COORD_BITS-1:0] i_third_x,
    input  logic [COORD_BITS-1:0] i_third_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_center_x,
    output logic signed [31:0]    o_center_y,
    output logic [30:0]           o_circle_radius,
    output logic                  o_collinear,
    output logic                  o_clipped
);
    import ccp_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int NW     = 3*C+4;
    localparam int DW     = 2*C+5;
    localparam int QW     = NW+FRAC_BITS+1;
    localparam int DTAG_W = 2*C+$bits(t_dflag);
    localparam int STAG_W = 2*OUT_W+$bits(t_sflag);

    logic              w_en;
    logic              nm_valid;
    logic [NW-1:0]     nm_anx, nm_any;
    logic [DW-1:0]     nm_ad;
    logic [C-1:0]      nm_x1, nm_y1;
    t_dflag            nm_flag;

    logic              dv_valid;
    logic [QW-1:0]     dv_qa, dv_qb;
    logic [DTAG_W-1:0] dv_tag;
    logic [C-1:0]      dv_x1, dv_y1;
    t_dflag            dv_flag;

    logic              ds_valid;
    logic [SQ_W-1:0]   ds_sq;
    logic [OUT_W-1:0]  ds_cx, ds_cy;
    t_sflag            ds_flag;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [REM_W-1:0]  sq_rem;
    logic [STAG_W-1:0] sq_tag;
    logic [OUT_W-1:0]  sq_cx, sq_cy;
    t_sflag            sq_flag;

    logic [LIM_W-1:0]  rad;
    logic              rad_clip;

    logic              r_o_valid;
    logic [OUT_W-1:0]  r_cx, r_cy;
    logic [RAD_W-1:0]  r_rad;
    logic              r_coll, r_clip;

    assign w_en    = !(r_o_valid && i_stall);
    assign o_stall = !w_en;

    ccp_numer #(.C(C), .NW(NW), .DW(DW)) u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x1    (i_first_x),
        .i_y1    (i_first_y),
        .i_x2    (i_second_x),
        .i_y2    (i_second_y),
        .i_x3    (i_third_x),
        .i_y3    (i_third_y),
        .o_valid (nm_valid),
        .o_anx   (nm_anx),
        .o_any   (nm_any),
        .o_ad    (nm_ad),
        .o_x1    (nm_x1),
        .o_y1    (nm_y1),
        .o_flag  (nm_flag)
    );

    ccp_div #(.NW(NW), .DW(DW), .F(FRAC_BITS), .TAG_W(DTAG_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (nm_valid),
        .i_num_a (nm_anx),
        .i_num_b (nm_any),
        .i_den   (nm_ad),
        .i_tag   ({nm_x1, nm_y1, nm_flag}),
        .o_valid (dv_valid),
        .o_quo_a (dv_qa),
        .o_quo_b (dv_qb),
        .o_tag   (dv_tag)
    );

    assign {dv_x1, dv_y1, dv_flag} = dv_tag;

    ccp_dist #(.C(C), .F(FRAC_BITS), .QW(QW)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (dv_valid),
        .i_quo_a (dv_qa),
        .i_quo_b (dv_qb),
        .i_x1    (dv_x1),
        .i_y1    (dv_y1),
        .i_flag  (dv_flag),
        .o_valid (ds_valid),
        .o_sq    (ds_sq),
        .o_cx    (ds_cx),
        .o_cy    (ds_cy),
        .o_flag  (ds_flag)
    );

    ccp_sqrt #(.TAG_W(STAG_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (ds_valid),
        .i_sq    (ds_sq),
        .i_tag   ({ds_cx, ds_cy, ds_flag}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_rem   (sq_rem),
        .o_tag   (sq_tag)
    );

    assign {sq_cx, sq_cy, sq_flag} = sq_tag;

    // round to nearest: bump when remainder exceeds the root
    assign rad      = {1'b0, sq_root} + LIM_W'(sq_rem > {1'b0, sq_root});
    assign rad_clip = sq_flag.big || (rad > POS_LIMIT);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (sq_flag.coll) begin
                r_cx   <= '0;
                r_cy   <= '0;
                r_rad  <= '0;
                r_coll <= 1'b1;
                r_clip <= 1'b0;
            end else begin
                r_cx   <= sq_cx;
                r_cy   <= sq_cy;
                r_rad  <= rad_clip ? POS_LIMIT[RAD_W-1:0] : rad[RAD_W-1:0];
                r_coll <= 1'b0;
                r_clip <= sq_flag.clip | rad_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= sq_valid;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_center_x      = $signed(r_cx);
    assign o_center_y      = $signed(r_cy);
    assign o_circle_radius = r_rad;
    assign o_collinear     = r_coll;
    assign o_clipped       = r_clip;

`ifndef SYNTHESIS
    a_coll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_collinear |-> o_center_x == 0 && o_center_y == 0
            && o_circle_radius == 0 && !o_clipped)
        else $error("collinear result carries nonzero fields");

    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a pending output");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(sq_valid) && $stable(ds_valid) && $stable(dv_valid))
        else $error("pipeline moved during stall");

    a_clip_not_coll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> !o_collinear)
        else $error("clipped and collinear both set");
`endif

endmodule

[rtl/ccp_numer.sv]
// Exact numerators and determinant: squares, products, sums, magnitudes (4 stages).
module ccp_numer #(
    parameter int C  = 12,
    parameter int NW = 3*C+4,
    parameter int DW = 2*C+5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [C-1:0]      i_x1,
    input  logic [C-1:0]      i_y1,
    input  logic [C-1:0]      i_x2,
    input  logic [C-1:0]      i_y2,
    input  logic [C-1:0]      i_x3,
    input  logic [C-1:0]      i_y3,
    output logic              o_valid,
    output logic [NW-1:0]     o_anx,
    output logic [NW-1:0]     o_any,
    output logic [DW-1:0]     o_ad,
    output logic [C-1:0]      o_x1,
    output logic [C-1:0]      o_y1,
    output ccp_pkg::t_dflag   o_flag
);
    import ccp_pkg::*;

    localparam int SW  = 2*C+1;
    localparam int DFW = C+1;
    localparam int PW  = SW+DFW;
    localparam int DPW = 2*C+2;
    localparam int DSW = DPW+2;

    logic [C-1:0]   x [0:2];
    logic [C-1:0]   y [0:2];
    logic [2*C-1:0] sqx [0:2];
    logic [2*C-1:0] sqy [0:2];

    logic                  r1_v, r2_v, r3_v, r4_v;
    logic [SW-1:0]         r1_s  [0:2];
    logic signed [DFW-1:0] r1_dy [0:2];
    logic signed [DFW-1:0] r1_dx [0:2];
    logic [C-1:0]          r1_x  [0:2];
    logic [C-1:0]          r1_y1;

    logic signed [PW-1:0]  r2_pnx [0:2];
    logic signed [PW-1:0]  r2_pny [0:2];
    logic signed [DPW-1:0] r2_pd  [0:2];
    logic [C-1:0]          r2_x1, r2_y1;

    logic signed [NW-1:0]  r3_nx, r3_ny;
    logic signed [DSW-1:0] r3_det;
    logic [C-1:0]          r3_x1, r3_y1;

    logic [NW-1:0]         r4_anx, r4_any;
    logic [DW-1:0]         r4_ad;
    logic [C-1:0]          r4_x1, r4_y1;
    t_dflag                r4_flag;

    logic [DSW-1:0]        abs_det;

    assign x[0] = i_x1;
    assign x[1] = i_x2;
    assign x[2] = i_x3;
    assign y[0] = i_y1;
    assign y[1] = i_y2;
    assign y[2] = i_y3;

    for (genvar i = 0; i < 3; i++) begin : g_pt
        assign sqx[i] = x[i] * x[i];
        assign sqy[i] = y[i] * y[i];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_s[i]  <= {1'b0, sqx[i]} + {1'b0, sqy[i]};
                r1_dy[i] <= $signed({1'b0, y[(i+1)%3]}) - $signed({1'b0, y[(i+2)%3]});
                r1_dx[i] <= $signed({1'b0, x[(i+2)%3]}) - $signed({1'b0, x[(i+1)%3]});
                r1_x[i]  <= x[i];
                r2_pnx[i] <= $signed({1'b0, r1_s[i]}) * r1_dy[i];
                r2_pny[i] <= $signed({1'b0, r1_s[i]}) * r1_dx[i];
                r2_pd[i]  <= $signed({1'b0, r1_x[i]}) * r1_dy[i];
            end
        end
    end

    assign abs_det = r3_det[DSW-1] ? DSW'(-r3_det) : DSW'(r3_det);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_y1  <= i_y1;
            r2_x1  <= r1_x[0];
            r2_y1  <= r1_y1;
            r3_nx  <= NW'(r2_pnx[0]) + NW'(r2_pnx[1]) + NW'(r2_pnx[2]);
            r3_ny  <= NW'(r2_pny[0]) + NW'(r2_pny[1]) + NW'(r2_pny[2]);
            r3_det <= DSW'(r2_pd[0]) + DSW'(r2_pd[1]) + DSW'(r2_pd[2]);
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
            r4_anx <= r3_nx[NW-1] ? NW'(-r3_nx) : NW'(r3_nx);
            r4_any <= r3_ny[NW-1] ? NW'(-r3_ny) : NW'(r3_ny);
            r4_ad  <= {abs_det, 1'b0};
            r4_x1  <= r3_x1;
            r4_y1  <= r3_y1;
            r4_flag.coll  <= (r3_det == '0);
            r4_flag.neg_x <= r3_nx[NW-1] ^ r3_det[DSW-1];
            r4_flag.neg_y <= r3_ny[NW-1] ^ r3_det[DSW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    assign o_valid = r4_v;
    assign o_anx   = r4_anx;
    assign o_any   = r4_any;
    assign o_ad    = r4_ad;
    assign o_x1    = r4_x1;
    assign o_y1    = r4_y1;
    assign o_flag  = r4_flag;

endmodule

[rtl/ccp_div.sv]
// Two-lane restoring divider with a shared divisor, one quotient bit per stage.
module ccp_div #(
    parameter int NW    = 40,
    parameter int DW    = 29,
    parameter int F     = 8,
    parameter int TAG_W = 27
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [NW-1:0]       i_num_a,
    input  logic [NW-1:0]       i_num_b,
    input  logic [DW-1:0]       i_den,
    input  logic [TAG_W-1:0]    i_tag,
    output logic                o_valid,
    output logic [NW+F:0]       o_quo_a,
    output logic [NW+F:0]       o_quo_b,
    output logic [TAG_W-1:0]    o_tag
);
    localparam int QW = NW+F+1;

    logic               r_v    [1:QW];
    logic [QW-1:0]      r_qa   [1:QW];
    logic [QW-1:0]      r_qb   [1:QW];
    logic [DW-1:0]      r_ra   [1:QW];
    logic [DW-1:0]      r_rb   [1:QW];
    logic [DW-1:0]      r_den  [1:QW];
    logic [TAG_W-1:0]   r_tag  [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             v;
        logic [QW-1:0]    qa, qb;
        logic [DW-1:0]    ra, rb, den;
        logic [TAG_W-1:0] tag;
        logic [DW:0]      ta, tb;
        logic             ga, gb;

        if (k == 0) begin : g_first
            assign v   = i_valid;
            assign qa  = QW'(i_num_a) << (F+1);
            assign qb  = QW'(i_num_b) << (F+1);
            assign ra  = '0;
            assign rb  = '0;
            assign den = i_den;
            assign tag = i_tag;
        end else begin : g_next
            assign v   = r_v[k];
            assign qa  = r_qa[k];
            assign qb  = r_qb[k];
            assign ra  = r_ra[k];
            assign rb  = r_rb[k];
            assign den = r_den[k];
            assign tag = r_tag[k];
        end

        assign ta = {ra, qa[QW-1]};
        assign tb = {rb, qb[QW-1]};
        assign ga = (ta >= {1'b0, den});
        assign gb = (tb >= {1'b0, den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ra[k+1]  <= ga ? DW'(ta - {1'b0, den}) : ta[DW-1:0];
                r_rb[k+1]  <= gb ? DW'(tb - {1'b0, den}) : tb[DW-1:0];
                r_qa[k+1]  <= {qa[QW-2:0], ga};
                r_qb[k+1]  <= {qb[QW-2:0], gb};
                r_den[k+1] <= den;
                r_tag[k+1] <= tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v;
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo_a = r_qa[QW];
    assign o_quo_b = r_qb[QW];
    assign o_tag   = r_tag[QW];

endmodule

[rtl/ccp_dist.sv]
// Rounding and saturation of the center, then squared distance to the first point (4 stages).
module ccp_dist #(
    parameter int C  = 12,
    parameter int F  = 8,
    parameter int QW = 49
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [QW-1:0]            i_quo_a,
    input  logic [QW-1:0]            i_quo_b,
    input  logic [C-1:0]             i_x1,
    input  logic [C-1:0]             i_y1,
    input  ccp_pkg::t_dflag          i_flag,
    output logic                     o_valid,
    output logic [ccp_pkg::SQ_W-1:0] o_sq,
    output logic [ccp_pkg::OUT_W-1:0] o_cx,
    output logic [ccp_pkg::OUT_W-1:0] o_cy,
    output ccp_pkg::t_sflag          o_flag
);
    import ccp_pkg::*;

    localparam int CW = (QW > LIM_W) ? QW : LIM_W;
    localparam int XW = OUT_W+2;

    function automatic logic [OUT_W:0] sat_fix(input logic [QW-1:0] quo, input logic neg);
        logic [QW:0]      sum;
        logic [CW-1:0]    m_ext;
        logic [CW-1:0]    l_ext;
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] m_sat;
        logic [LIM_W-1:0] sgn;
        logic             over;
        sum   = {1'b0, quo} + (QW+1)'(1);
        lim   = neg ? NEG_LIMIT : POS_LIMIT;
        m_ext = CW'(sum[QW:1]);
        l_ext = CW'(lim);
        over  = (m_ext > l_ext);
        m_sat = over ? lim : m_ext[LIM_W-1:0];
        sgn   = neg ? (~m_sat + 1'b1) : m_sat;
        return {over, sgn[OUT_W-1:0]};
    endfunction

    function automatic logic [XW-1:0] abs_off(input logic [OUT_W-1:0] c,
                                              input logic [C-1:0] p);
        logic [XW-1:0] d;
        d = {c[OUT_W-1], c[OUT_W-1], c} - {1'b0, (LIM_W'(p) << F)};
        return d[XW-1] ? (~d + 1'b1) : d;
    endfunction

    logic [OUT_W:0]   sx, sy;
    logic [XW-1:0]    adx, ady;

    logic             r1_v, r2_v, r3_v, r4_v;
    logic [OUT_W-1:0] r1_cx, r1_cy, r2_cx, r2_cy, r3_cx, r3_cy, r4_cx, r4_cy;
    logic [C-1:0]     r1_x1, r1_y1;
    t_sflag           r1_f, r2_f, r3_f, r4_f;
    logic [AD_W-1:0]  r2_adx, r2_ady;
    logic [2*AD_W-1:0] r3_px, r3_py;
    logic [SQ_W-1:0]  r4_sq;

    assign sx  = sat_fix(i_quo_a, i_flag.neg_x);
    assign sy  = sat_fix(i_quo_b, i_flag.neg_y);
    assign adx = abs_off(r1_cx, r1_x1);
    assign ady = abs_off(r1_cy, r1_y1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cx     <= sx[OUT_W-1:0];
            r1_cy     <= sy[OUT_W-1:0];
            r1_x1     <= i_x1;
            r1_y1     <= i_y1;
            r1_f.coll <= i_flag.coll;
            r1_f.clip <= sx[OUT_W] | sy[OUT_W];
            r1_f.big  <= 1'b0;

            r2_cx     <= r1_cx;
            r2_cy     <= r1_cy;
            r2_adx    <= adx[AD_W-1:0];
            r2_ady    <= ady[AD_W-1:0];
            r2_f.coll <= r1_f.coll;
            r2_f.clip <= r1_f.clip;
            r2_f.big  <= (adx > XW'(POS_LIMIT)) || (ady > XW'(POS_LIMIT));

            r3_cx     <= r2_cx;
            r3_cy     <= r2_cy;
            r3_px     <= r2_adx * r2_adx;
            r3_py     <= r2_ady * r2_ady;
            r3_f      <= r2_f;

            r4_cx     <= r3_cx;
            r4_cy     <= r3_cy;
            r4_sq     <= {1'b0, r3_px} + {1'b0, r3_py};
            r4_f      <= r3_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    assign o_valid = r4_v;
    assign o_sq    = r4_sq;
    assign o_cx    = r4_cx;
    assign o_cy    = r4_cy;
    assign o_flag  = r4_f;

endmodule

[rtl/ccp_sqrt.sv]
// Restoring integer square root, one root bit per stage, with final remainder.
module ccp_sqrt #(
    parameter int TAG_W = 67
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [ccp_pkg::SQ_W-1:0]   i_sq,
    input  logic [TAG_W-1:0]           i_tag,
    output logic                       o_valid,
    output logic [ccp_pkg::ROOT_W-1:0] o_root,
    output logic [ccp_pkg::REM_W-1:0]  o_rem,
    output logic [TAG_W-1:0]           o_tag
);
    import ccp_pkg::*;

    localparam int SRC_W = 2*ROOT_W;
    localparam int TW    = REM_W+2;

    logic               r_v    [1:ROOT_W];
    logic [SRC_W-1:0]   r_src  [1:ROOT_W];
    logic [REM_W-1:0]   r_rem  [1:ROOT_W];
    logic [ROOT_W-1:0]  r_root [1:ROOT_W];
    logic [TAG_W-1:0]   r_tag  [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v;
        logic [SRC_W-1:0]  src;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [TAG_W-1:0]  tag;
        logic [TW-1:0]     tr, trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign v    = i_valid;
            assign src  = SRC_W'(i_sq);
            assign rem  = '0;
            assign root = '0;
            assign tag  = i_tag;
        end else begin : g_next
            assign v    = r_v[k];
            assign src  = r_src[k];
            assign rem  = r_rem[k];
            assign root = r_root[k];
            assign tag  = r_tag[k];
        end

        assign tr    = {rem, src[SRC_W-1 -: 2]};
        assign trial = TW'({root, 2'b01});
        assign ge    = (tr >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_src[k+1]  <= {src[SRC_W-3:0], 2'b00};
                r_rem[k+1]  <= ge ? REM_W'(tr - trial) : tr[REM_W-1:0];
                r_root[k+1] <= {root[ROOT_W-2:0], ge};
                r_tag[k+1]  <= tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v;
            end
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_rem   = r_rem[ROOT_W];
    assign o_tag   = r_tag[ROOT_W];

endmodule
